// ===== rtl/sefp_pkg.sv =====
// Shared types and constants for the STX/ETX frame parser with Fletcher checksum.
package sefp_pkg;

   // Framing bytes.
   localparam logic [7:0] START_BYTE = 8'h02;
   localparam logic [7:0] END_BYTE   = 8'h03;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // Frame end status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_CHECKSUM = 2'd1;
   localparam logic [1:0] STATUS_BAD_END  = 2'd2;
   localparam logic [1:0] STATUS_UNUSED   = 2'd3;

   // One result beat.
   typedef struct packed {
      logic       kind;
      logic [1:0] status;
      logic [7:0] frame_command;
      logic [7:0] frame_length;
      logic [7:0] byte_index;
      logic [7:0] byte_value;
   } result_type;

endpackage

// ===== rtl/stx_etx_frame_parser_fletcher.sv =====
// Top level of the STX/ETX frame parser with a Fletcher-style checksum pair.
//
// Usage:
//   The request channel (req_valid, req_stall, req_rx_byte) takes one received
//   serial byte per beat. Frames are: start 0x02, command, length, payload
//   bytes, checksum A, checksum B, end 0x03.
//   The response channel (rsp_valid, rsp_stall, rsp_*) gives one beat for
//   each payload byte (kind 0, with its index and value) and one status beat
//   for the byte in the end position (kind 1: ok, checksum mismatch or bad
//   end byte). Other bytes give no beat.
//   Result path: a result from an accepted byte is registered into the output
//   register, or into the skid register while the output register is held.
//   Throughput: one byte per cycle while req_stall is low; the parse state
//   updates in the accepting cycle and the result goes into the output or skid register.
//   Stalls: a two-entry output buffer (output register plus skid register)
//   sits on the response side. req_stall is high only while the skid register
//   holds a beat, so the request side keeps flowing while only the output
//   register is held and stops only when both entries are full.
//   Reset (synchronous, active high) clears the parse state to waiting for a
//   start byte, zeroes the sums and header and empties both output entries.
module stx_etx_frame_parser_fletcher
   import sefp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // Response channel.
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_frame_command,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_byte_value
);

   typedef enum logic [2:0] {
      PH_WAIT_START = 3'd0,
      PH_COMMAND    = 3'd1,
      PH_LENGTH     = 3'd2,
      PH_PAYLOAD    = 3'd3,
      PH_SUM_B      = 3'd4,
      PH_END        = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] sum_a_ff, sum_a_in;
   logic [7:0] sum_b_ff, sum_b_in;
   logic [7:0] command_ff, command_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] rx_sum_a_ff, rx_sum_a_in;
   logic [7:0] rx_sum_b_ff, rx_sum_b_in;

   logic       accept;
   logic       new_valid;
   result_type new_result;
   logic [7:0] acc_a;
   logic [7:0] acc_b;

   logic       out_valid_ff;
   result_type out_ff;
   logic       skid_valid_ff;
   result_type skid_ff;
   logic       out_take;

   assign accept   = req_valid && !req_stall;
   assign out_take = out_valid_ff && !rsp_stall;

   // Running Fletcher sums with the current byte folded in.
   assign acc_a = sum_a_ff + req_rx_byte;
   assign acc_b = sum_b_ff + acc_a;

   // Next parse state and the result caused by the current byte.
   always_comb begin
      phase_in    = phase_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      rx_sum_a_in = rx_sum_a_ff;
      rx_sum_b_in = rx_sum_b_ff;
      new_valid   = 1'b0;
      new_result  = '{kind: KIND_PAYLOAD, status: STATUS_OK,
                      frame_command: command_ff, frame_length: length_ff,
                      byte_index: 8'd0, byte_value: 8'd0};
      unique case (phase_ff)
         PH_WAIT_START: begin
            // Any byte seeds the sums and clears the header.
            if (req_rx_byte == START_BYTE) begin
               phase_in = PH_COMMAND;
            end
            sum_a_in   = req_rx_byte;
            sum_b_in   = req_rx_byte;
            command_in = 8'd0;
            length_in  = 8'd0;
            count_in   = 8'd0;
         end
         PH_COMMAND: begin
            command_in = req_rx_byte;
            sum_a_in   = acc_a;
            sum_b_in   = acc_b;
            phase_in   = PH_LENGTH;
         end
         PH_LENGTH: begin
            length_in = req_rx_byte;
            sum_a_in  = acc_a;
            sum_b_in  = acc_b;
            phase_in  = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (count_ff < length_ff) begin
               sum_a_in              = acc_a;
               sum_b_in              = acc_b;
               new_valid             = 1'b1;
               new_result.byte_index = count_ff;
               new_result.byte_value = req_rx_byte;
               count_in              = count_ff + 8'd1;
            end else begin
               // Payload done: this byte is checksum A.
               rx_sum_a_in = req_rx_byte;
               phase_in    = PH_SUM_B;
            end
         end
         PH_SUM_B: begin
            rx_sum_b_in = req_rx_byte;
            phase_in    = PH_END;
         end
         PH_END: begin
            new_valid       = 1'b1;
            new_result.kind = KIND_STATUS;
            if (req_rx_byte != END_BYTE) begin
               new_result.status = STATUS_BAD_END;
            end else if (rx_sum_a_ff == sum_a_ff && rx_sum_b_ff == sum_b_ff) begin
               new_result.status = STATUS_OK;
            end else begin
               new_result.status = STATUS_CHECKSUM;
            end
            phase_in = PH_WAIT_START;
         end
         default: begin
            phase_in = PH_WAIT_START;
         end
      endcase
   end

   // Parse state, output register and skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT_START;
         sum_a_ff      <= 8'd0;
         sum_b_ff      <= 8'd0;
         command_ff    <= 8'd0;
         length_ff     <= 8'd0;
         count_ff      <= 8'd0;
         rx_sum_a_ff   <= 8'd0;
         rx_sum_b_ff   <= 8'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         out_ff        <= '0;
         skid_ff       <= '0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            sum_a_ff    <= sum_a_in;
            sum_b_ff    <= sum_b_in;
            command_ff  <= command_in;
            length_ff   <= length_in;
            count_ff    <= count_in;
            rx_sum_a_ff <= rx_sum_a_in;
            rx_sum_b_ff <= rx_sum_b_in;
         end
         if (skid_valid_ff) begin
            if (out_take) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
               out_ff        <= skid_ff;
            end
         end else if (!out_valid_ff || out_take) begin
            out_valid_ff <= accept && new_valid;
            out_ff       <= new_result;
         end else begin
            if (accept && new_valid) begin
               skid_valid_ff <= 1'b1;
            end
            skid_ff <= new_result;
         end
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_status        = out_ff.status;
   assign rsp_frame_command = out_ff.frame_command;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_byte_index    = out_ff.byte_index;
   assign rsp_byte_value    = out_ff.byte_value;

endmodule

// ===== rtl/sefp_checker.sv =====
// Port-level checker for the frame parser, bound to its top level.
module sefp_checker
   import sefp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_rx_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_kind,
   input logic [1:0] rsp_status,
   input logic [7:0] rsp_frame_command,
   input logic [7:0] rsp_frame_length,
   input logic [7:0] rsp_byte_index,
   input logic [7:0] rsp_byte_value
);

   // A stalled request beat holds its valid and byte.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_rx_byte))
      else $error("stalled request beat changed");

   // A stalled response beat holds its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_status)
         && $stable(rsp_byte_index) && $stable(rsp_byte_value)
         && $stable(rsp_frame_command) && $stable(rsp_frame_length))
      else $error("stalled response beat changed");

   // The output buffer is empty right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The request side stalls only when the output register is full.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty output");

   // Payload beats carry no status; status beats carry a legal code and no byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_PAYLOAD && rsp_status == STATUS_OK)
         || (rsp_kind == KIND_STATUS && rsp_status != STATUS_UNUSED
             && rsp_byte_index == 8'd0 && rsp_byte_value == 8'd0))
      else $error("inconsistent response beat fields");

endmodule

bind stx_etx_frame_parser_fletcher sefp_checker u_sefp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_rx_byte      (req_rx_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_status       (rsp_status),
   .rsp_frame_command(rsp_frame_command),
   .rsp_frame_length (rsp_frame_length),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_byte_value   (rsp_byte_value)
);

// ===== tb/sv/stx_etx_frame_parser_fletcher_test.sv =====
// Self-checking testbench for the STX/ETX frame parser with Fletcher checksum.
module stx_etx_frame_parser_fletcher_test;
   import sefp_pkg::*;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int QUIET_LIMIT     = 2000;
   localparam int MAX_REPORTS     = 10;

   // Parser position within a frame, as the predictor tracks it.
   typedef enum logic [2:0] {
      WAIT_START,
      TAKE_COMMAND,
      TAKE_LENGTH,
      TAKE_BODY,
      TAKE_CHECK_B,
      TAKE_END
   } parse_phase_type;

   // One row of the directed stimulus; typed rows carry their expected beat.
   typedef struct packed {
      logic [7:0] rx;
      bit         typed;
      result_type want;
   } stim_row_type;

   localparam result_type NO_BEAT = '0;

   // A good frame, a zero-length frame with a bad checksum, then noise and a
   // frame whose end byte is wrong.
   localparam stim_row_type DIRECTED_ROWS [23] = '{
      '{8'h02, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, NO_BEAT},
      '{8'h01, 1'b0, NO_BEAT},
      '{8'h00, 1'b1, '{KIND_PAYLOAD, STATUS_OK, 8'hFF, 8'h01, 8'h00, 8'h00}},
      '{8'h02, 1'b0, NO_BEAT},
      '{8'h07, 1'b0, NO_BEAT},
      '{8'h03, 1'b1, '{KIND_STATUS, STATUS_OK, 8'hFF, 8'h01, 8'h00, 8'h00}},
      '{8'h02, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT},
      '{8'hFF, 1'b0, NO_BEAT},
      '{8'h03, 1'b1, '{KIND_STATUS, STATUS_CHECKSUM, 8'h00, 8'h00, 8'h00, 8'h00}},
      '{8'hFF, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, NO_BEAT},
      '{8'h02, 1'b0, NO_BEAT},
      '{8'h80, 1'b0, NO_BEAT},
      '{8'h02, 1'b0, NO_BEAT},
      '{8'hFF, 1'b1, '{KIND_PAYLOAD, STATUS_OK, 8'h80, 8'h02, 8'h00, 8'hFF}},
      '{8'h7F, 1'b1, '{KIND_PAYLOAD, STATUS_OK, 8'h80, 8'h02, 8'h01, 8'h7F}},
      '{8'h11, 1'b0, NO_BEAT},
      '{8'h22, 1'b0, NO_BEAT},
      '{8'hFF, 1'b1, '{KIND_STATUS, STATUS_BAD_END, 8'h80, 8'h02, 8'h00, 8'h00}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [1:0] rsp_status;
   logic [7:0] rsp_frame_command;
   logic [7:0] rsp_frame_length;
   logic [7:0] rsp_byte_index;
   logic [7:0] rsp_byte_value;

   // Side information that travels with the byte on offer.
   bit         offer_typed = 1'b0;
   result_type offer_want = '0;

   // Predictor state.
   parse_phase_type parse_phase = WAIT_START;
   logic [7:0]      acc_first = '0;
   logic [7:0]      acc_second = '0;
   logic [7:0]      frame_cmd = '0;
   logic [7:0]      frame_len = '0;
   logic [7:0]      bytes_seen = '0;
   logic [7:0]      sent_check_a = '0;
   logic [7:0]      sent_check_b = '0;

   result_type pending_beats [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_taken = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int frame_bytes = 0;
   int noise_bytes = 0;
   int payload_beats = 0;
   int ends_ok = 0;
   int ends_checksum = 0;
   int ends_bad = 0;

   stx_etx_frame_parser_fletcher uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_frame_command (rsp_frame_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_byte_value    (rsp_byte_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the frame parse by one byte; returns 1 when the byte yields a beat.
   function automatic bit parse_rx_byte(input logic [7:0] rx, output result_type beat);
      bit made;
      logic [1:0] verdict;
      made = 1'b0;
      beat = '0;
      case (parse_phase)
         WAIT_START: begin
            // Any byte reseeds the sums; only the start byte opens a frame.
            if (rx == START_BYTE) parse_phase = TAKE_COMMAND;
            acc_first  = rx;
            acc_second = rx;
            frame_cmd  = '0;
            frame_len  = '0;
            bytes_seen = '0;
         end
         TAKE_COMMAND: begin
            frame_cmd   = rx;
            acc_first   = acc_first + rx;
            acc_second  = acc_second + acc_first;
            parse_phase = TAKE_LENGTH;
         end
         TAKE_LENGTH: begin
            frame_len   = rx;
            acc_first   = acc_first + rx;
            acc_second  = acc_second + acc_first;
            parse_phase = TAKE_BODY;
         end
         TAKE_BODY: begin
            // Once the declared payload is in, the next byte is checksum A.
            if (bytes_seen < frame_len) begin
               acc_first  = acc_first + rx;
               acc_second = acc_second + acc_first;
               beat = '{KIND_PAYLOAD, STATUS_OK, frame_cmd, frame_len, bytes_seen, rx};
               made = 1'b1;
               bytes_seen = bytes_seen + 8'd1;
            end else begin
               sent_check_a = rx;
               parse_phase  = TAKE_CHECK_B;
            end
         end
         TAKE_CHECK_B: begin
            sent_check_b = rx;
            parse_phase  = TAKE_END;
         end
         TAKE_END: begin
            if (rx != END_BYTE)
               verdict = STATUS_BAD_END;
            else if (sent_check_a == acc_first && sent_check_b == acc_second)
               verdict = STATUS_OK;
            else
               verdict = STATUS_CHECKSUM;
            beat = '{KIND_STATUS, verdict, frame_cmd, frame_len, 8'h00, 8'h00};
            made = 1'b1;
            parse_phase = WAIT_START;
         end
         default: parse_phase = WAIT_START;
      endcase
      return made;
   endfunction

   task automatic note_mismatch(input string what, input result_type want,
                                input result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("MISMATCH %s: expected kind=%0d status=%0d cmd=%02h len=%02h idx=%02h val=%02h",
                  what, want.kind, want.status, want.frame_command, want.frame_length,
                  want.byte_index, want.byte_value);
         $display("   got kind=%0d status=%0d cmd=%02h len=%02h idx=%02h val=%02h",
                  got.kind, got.status, got.frame_command, got.frame_length,
                  got.byte_index, got.byte_value);
      end
   endtask

   // Receiver: a long hold-off when one is asked for, otherwise random stalls.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_taken != hold_requests) begin
         rsp_stall  <= 1'b1;
         hold_left  <= HOLD_OFF_CYCLES - 1;
         hold_taken <= hold_requests;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: checks result beats, predicts from accepted bytes, and watches
   // for a hung handshake.
   always @(posedge clock) begin
      result_type got_beat;
      result_type want_beat;
      result_type next_beat;
      bit         made_beat;
      string      diff;
      if (reset) begin
         parse_phase  = WAIT_START;
         acc_first    = '0;
         acc_second   = '0;
         frame_cmd    = '0;
         frame_len    = '0;
         bytes_seen   = '0;
         sent_check_a = '0;
         sent_check_b = '0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_beat = '{rsp_kind, rsp_status, rsp_frame_command, rsp_frame_length,
                         rsp_byte_index, rsp_byte_value};
            if (pending_beats.size() == 0) begin
               note_mismatch("unexpected beat", NO_BEAT, got_beat);
            end else begin
               want_beat = pending_beats.pop_front();
               diff = "";
               if (got_beat.kind !== want_beat.kind) diff = {diff, " kind"};
               if (got_beat.status !== want_beat.status) diff = {diff, " status"};
               if (got_beat.frame_command !== want_beat.frame_command)
                  diff = {diff, " command"};
               if (got_beat.frame_length !== want_beat.frame_length)
                  diff = {diff, " length"};
               if (got_beat.byte_index !== want_beat.byte_index) diff = {diff, " index"};
               if (got_beat.byte_value !== want_beat.byte_value) diff = {diff, " value"};
               if (diff != "") note_mismatch({"in", diff}, want_beat, got_beat);
               if (want_beat.kind == KIND_PAYLOAD) payload_beats++;
               else if (want_beat.status == STATUS_OK) ends_ok++;
               else if (want_beat.status == STATUS_CHECKSUM) ends_checksum++;
               else ends_bad++;
            end
         end
         if (req_valid && !req_stall) begin
            made_beat = parse_rx_byte(req_rx_byte, next_beat);
            if (offer_typed) pending_beats.push_back(offer_want);
            else if (made_beat) pending_beats.push_back(next_beat);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Offer one byte, with random idle cycles ahead of it, and wait for it to go.
   task automatic offer_byte(input logic [7:0] rx, input bit typed, input result_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      offer_typed <= typed;
      offer_want  <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send one whole frame with random payload; the checksum can be spoiled.
   task automatic send_frame(input logic [7:0] command, input logic [7:0] length,
                             input bit bad_sum, input logic [7:0] end_byte);
      logic [7:0] chk_a;
      logic [7:0] chk_b;
      logic [7:0] body;
      int         i;
      chk_a = START_BYTE + command;
      chk_b = START_BYTE + chk_a;
      chk_a = chk_a + length;
      chk_b = chk_b + chk_a;
      offer_byte(START_BYTE, 1'b0, NO_BEAT);
      offer_byte(command, 1'b0, NO_BEAT);
      offer_byte(length, 1'b0, NO_BEAT);
      for (i = 0; i < length; i++) begin
         body  = 8'($urandom);
         chk_a = chk_a + body;
         chk_b = chk_b + chk_a;
         offer_byte(body, 1'b0, NO_BEAT);
      end
      if (bad_sum) begin
         if ($urandom_range(1) == 1) chk_a = chk_a ^ (8'h01 << $urandom_range(7));
         else chk_b = chk_b ^ (8'h01 << $urandom_range(7));
      end
      offer_byte(chk_a, 1'b0, NO_BEAT);
      offer_byte(chk_b, 1'b0, NO_BEAT);
      offer_byte(end_byte, 1'b0, NO_BEAT);
      frame_bytes += int'(length) + 6;
   endtask

   // Mostly well-formed frames of small size, with noise and damaged frames mixed in.
   task automatic random_traffic(input int byte_goal);
      int         goal_at;
      int         pick;
      logic [7:0] length;
      logic [7:0] end_byte;
      goal_at = frame_bytes + byte_goal;
      while (frame_bytes < goal_at) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 3)) begin
               offer_byte(8'($urandom), 1'b0, NO_BEAT);
               noise_bytes++;
            end
         end else begin
            pick = $urandom_range(99);
            if (pick < 1) length = 8'hFF;
            else if (pick < 10) length = 8'($urandom_range(9, 64));
            else length = 8'($urandom_range(0, 8));
            end_byte = END_BYTE;
            if ($urandom_range(99) < 10)
               do end_byte = 8'($urandom); while (end_byte == END_BYTE);
            send_frame(8'($urandom), length, $urandom_range(99) < 15, end_byte);
         end
      end
   endtask

   // Stop offering and wait for every expected beat to come out.
   task automatic drain_beats;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_beats.size() != 0);
   endtask

   // Main sequence: directed table, then three idling regimes of random traffic.
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[r])
         offer_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      drain_beats();

      // Receiver holds off while a long frame keeps coming, to back up the input.
      recv_idle_pct <= 65;
      hold_requests <= hold_requests + 1;
      send_frame(8'($urandom), 8'd24, 1'b0, END_BYTE);
      send_idle_pct = 24;
      random_traffic(300);
      drain_beats();

      send_idle_pct = 65;
      recv_idle_pct <= 24;
      random_traffic(300);
      drain_beats();

      // Full rate both ways, including a frame of the largest length.
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      send_frame(8'($urandom), 8'hFF, 1'b0, END_BYTE);
      random_traffic(300);
      drain_beats();

      repeat (4) @(posedge clock);
      while (pending_beats.size() != 0)
         note_mismatch("missing beat", pending_beats.pop_front(), NO_BEAT);

      $display("Sent %0d frame bytes and %0d noise bytes; checked %0d payload beats.",
               frame_bytes, noise_bytes, payload_beats);
      $display("Frame ends seen: %0d ok, %0d checksum mismatch, %0d bad end; %0d mismatches.",
               ends_ok, ends_checksum, ends_bad, mismatches);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
